// ----- src/sds_pkg.sv -----
// Shared types and codes for the sample drill sequencer.
// No dependencies; imported by every module of the block.
package sds_pkg;

    localparam logic [1:0] CMD_UPDATE  = 2'd0;
    localparam logic [1:0] CMD_PREPARE = 2'd1;
    localparam logic [1:0] CMD_DRILL   = 2'd2;
    localparam logic [1:0] CMD_COLLECT = 2'd3;

    localparam logic [2:0] MODE_UNKNOWN    = 3'd0;
    localparam logic [2:0] MODE_PREPARING  = 3'd1;
    localparam logic [2:0] MODE_READY      = 3'd2;
    localparam logic [2:0] MODE_DRILLING   = 3'd3;
    localparam logic [2:0] MODE_COLLECTING = 3'd4;
    localparam logic [2:0] MODE_CLEANING   = 3'd5;

    localparam logic [2:0] DRL_UNKNOWN    = 3'd0;
    localparam logic [2:0] DRL_READY      = 3'd1;
    localparam logic [2:0] DRL_DRILLING   = 3'd2;
    localparam logic [2:0] DRL_CLEANING   = 3'd3;
    localparam logic [2:0] DRL_RETRIEVING = 3'd4;

    localparam logic [1:0] CNT_CLOSED = 2'd1;
    localparam logic [1:0] CNT_READY  = 2'd2;

    localparam int ACT_CLOSE     = 0;
    localparam int ACT_NEXT      = 1;
    localparam int ACT_TARE      = 2;
    localparam int ACT_HOME      = 3;
    localparam int ACT_DRILL     = 4;
    localparam int ACT_RETRACT   = 5;
    localparam int ACT_STOPCLEAN = 6;
    localparam int ACT_STOPRETR  = 7;
    localparam int ACT_RETRIEVE  = 8;
    localparam int ACT_CLEAN     = 9;
    localparam int ACT_W         = 10;

    localparam logic [1:0] CFG_DRILL_DUR   = 2'd0;
    localparam logic [1:0] CFG_RETR_TMO    = 2'd1;
    localparam logic [1:0] CFG_CLEAN_DUR   = 2'd2;
    localparam logic [1:0] CFG_TARGET_WGT  = 2'd3;

    typedef struct packed {
        logic [31:0]        drill_duration_ms;
        logic [31:0]        retrieve_timeout_ms;
        logic [31:0]        clean_duration_ms;
        logic signed [23:0] weight_goal;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         command;
        logic [2:0]         drill_status;
        logic [1:0]         container_status;
        logic signed [23:0] sample_weight;
        logic [31:0]        now_ms;
    } t_item;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] drill_start;
        logic [31:0] retrieve_start;
        logic [31:0] clean_start;
    } t_state;

endpackage

// ----- src/sds_cfg.sv -----
// Configuration register file of the sample drill sequencer.
// Depends on sds_pkg for the register indexes and the t_cfg bundle.
module sds_cfg
    import sds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr,
    input  logic [1:0]  i_index,
    input  logic [31:0] i_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drill_duration_ms   <= 32'd10000;
            r_cfg.retrieve_timeout_ms <= 32'd30000;
            r_cfg.clean_duration_ms   <= 32'd5000;
            r_cfg.weight_goal         <= 24'sd1000;
        end else if (i_wr) begin
            case (i_index)
                CFG_DRILL_DUR:  r_cfg.drill_duration_ms   <= i_data;
                CFG_RETR_TMO:   r_cfg.retrieve_timeout_ms <= i_data;
                CFG_CLEAN_DUR:  r_cfg.clean_duration_ms   <= i_data;
                CFG_TARGET_WGT: r_cfg.weight_goal         <= $signed(i_data[23:0]);
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/sds_step.sv -----
// Next-state and action logic for one command of the sample drill sequencer.
// Depends on sds_pkg for codes and the t_cfg, t_item and t_state bundles.
module sds_step
    import sds_pkg::*;
(
    input  t_cfg              i_cfg,
    input  t_item             i_item,
    input  t_state            i_state,
    output t_state            o_state,
    output logic [ACT_W-1:0]  o_actions
);

    logic [31:0] drill_elapsed;
    logic [31:0] retr_elapsed;
    logic [31:0] clean_elapsed;
    logic        drill_done;
    logic        retr_done;
    logic        clean_done;
    logic        cnt_ready;

    assign drill_elapsed = i_item.now_ms - i_state.drill_start;
    assign retr_elapsed  = i_item.now_ms - i_state.retrieve_start;
    assign clean_elapsed = i_item.now_ms - i_state.clean_start;
    assign drill_done    = drill_elapsed >= i_cfg.drill_duration_ms;
    assign clean_done    = clean_elapsed >= i_cfg.clean_duration_ms;
    assign retr_done     = (retr_elapsed >= i_cfg.retrieve_timeout_ms)
                         || ($signed(i_item.sample_weight) >= $signed(i_cfg.weight_goal));
    assign cnt_ready     = i_item.container_status == CNT_READY;

    always_comb begin
        o_state   = i_state;
        o_actions = '0;
        case (i_item.command)
            CMD_PREPARE: begin
                if (i_state.mode == MODE_UNKNOWN || i_state.mode == MODE_PREPARING) begin
                    o_state.mode = MODE_PREPARING;
                    if (i_item.container_status != CNT_CLOSED)
                        o_actions[ACT_CLOSE] = 1'b1;
                    case (i_item.drill_status)
                        DRL_UNKNOWN:    o_actions[ACT_HOME]      = 1'b1;
                        DRL_DRILLING:   o_actions[ACT_RETRACT]   = 1'b1;
                        DRL_CLEANING:   o_actions[ACT_STOPCLEAN] = 1'b1;
                        DRL_RETRIEVING: o_actions[ACT_STOPRETR]  = 1'b1;
                        default: ;
                    endcase
                end
            end
            CMD_DRILL: begin
                if (i_state.mode == MODE_READY) begin
                    o_state.mode        = MODE_DRILLING;
                    o_state.drill_start = i_item.now_ms;
                    o_actions[ACT_DRILL] = 1'b1;
                end
            end
            CMD_COLLECT: begin
                if (i_state.mode == MODE_READY) begin
                    o_state.mode        = MODE_COLLECTING;
                    o_actions[ACT_NEXT] = 1'b1;
                end
            end
            default: begin
                case (i_state.mode)
                    MODE_UNKNOWN, MODE_PREPARING: begin
                        if (i_item.drill_status == DRL_READY
                            && i_item.container_status == CNT_CLOSED)
                            o_state.mode = MODE_READY;
                    end
                    MODE_DRILLING: begin
                        if (i_item.drill_status == DRL_READY)
                            o_state.mode = MODE_READY;
                        else if (i_item.drill_status == DRL_DRILLING && drill_done)
                            o_actions[ACT_RETRACT] = 1'b1;
                    end
                    MODE_COLLECTING: begin
                        if (cnt_ready && i_item.drill_status != DRL_RETRIEVING) begin
                            o_actions[ACT_TARE]     = 1'b1;
                            o_actions[ACT_RETRIEVE] = 1'b1;
                            o_state.retrieve_start  = i_item.now_ms;
                        end else if (cnt_ready && retr_done) begin
                            o_actions[ACT_STOPRETR] = 1'b1;
                            o_actions[ACT_CLEAN]    = 1'b1;
                            o_state.clean_start     = i_item.now_ms;
                            o_state.mode            = MODE_CLEANING;
                        end
                    end
                    MODE_CLEANING: begin
                        if (cnt_ready && i_item.drill_status == DRL_CLEANING && clean_done) begin
                            o_actions[ACT_STOPCLEAN] = 1'b1;
                            o_actions[ACT_CLOSE]     = 1'b1;
                        end else if (i_item.container_status == CNT_CLOSED) begin
                            o_state.mode = MODE_READY;
                        end
                    end
                    default: ;
                endcase
            end
        endcase
    end

endmodule

// ----- src/sample_drill_sequencer_core.sv -----
// Top level of the sample drill sequencer: input register, step logic, result register.
// Depends on sds_pkg, sds_cfg and sds_step.
// Two register stages: the input register feeds the step logic, whose result goes to the result register.
// One item per cycle while i_stall is low; a stalled result holds a full input register and raises o_stall.
// Reset (synchronous, active low) sets mode unknown, start times zero, configuration registers to defaults.
module sample_drill_sequencer_core
    import sds_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_command,
    input  logic [2:0]         i_drill_status,
    input  logic [1:0]         i_container_status,
    input  logic signed [23:0] i_sample_weight,
    input  logic [31:0]        i_now_ms,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_system_mode,
    output logic [ACT_W-1:0]   o_actions,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    t_cfg             cfg;
    t_item            r_item;
    logic             r_in_valid;
    t_state           r_state;
    t_state           n_state;
    logic [ACT_W-1:0] n_actions;
    logic             r_out_valid;
    logic [2:0]       r_mode_out;
    logic [ACT_W-1:0] r_actions;
    logic             advance;
    logic             load;

    assign o_cfg_ready = 1'b1;

    sds_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    sds_step u_step (
        .i_cfg     (cfg),
        .i_item    (r_item),
        .i_state   (r_state),
        .o_state   (n_state),
        .o_actions (n_actions)
    );

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign load    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (load)
                r_in_valid <= 1'b1;
            else if (advance)
                r_in_valid <= 1'b0;
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.command          <= i_command;
            r_item.drill_status     <= i_drill_status;
            r_item.container_status <= i_container_status;
            r_item.sample_weight    <= i_sample_weight;
            r_item.now_ms           <= i_now_ms;
        end
        if (advance) begin
            r_mode_out <= n_state.mode;
            r_actions  <= n_actions;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_system_mode = r_mode_out;
    assign o_actions     = r_actions;

endmodule

// ----- src/sds_checker.sv -----
// Port-level checks for sample_drill_sequencer_core, bound to the top level.
// Depends on sds_pkg for mode codes and action bit positions.
module sds_checker
    import sds_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_stall,
    input logic [2:0]       o_system_mode,
    input logic [ACT_W-1:0] o_actions
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_system_mode) && $stable(o_actions))
        else $error("result changed while stalled");

    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_system_mode <= MODE_CLEANING)
        else $error("unreachable mode reported");

    a_drill_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_actions[ACT_DRILL] |-> o_system_mode == MODE_DRILLING)
        else $error("drill ordered outside drilling mode");

    a_retrieve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_actions[ACT_RETRIEVE]
        |-> o_actions[ACT_TARE] && o_system_mode == MODE_COLLECTING)
        else $error("retrieve ordered without tare or outside collecting mode");

endmodule

bind sample_drill_sequencer_core sds_checker u_sds_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_system_mode (o_system_mode),
    .o_actions     (o_actions)
);
